### src/pll_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pll_pkg: shared types and constants of the pooled linked list engine
// command and status codes, result record and sequencer states
// ----------------------------------------------------------------------------
package pll_pkg;

    localparam int CMD_W      = 3;
    localparam int IN_VALUE_W = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int POS_W      = 5;
    localparam int OUT_VALUE_W = 32;
    localparam int MAX_DUMP   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD  = 3'd0,
        CMD_INS_TAIL  = 3'd1,
        CMD_DELETE    = 3'd2,
        CMD_SEARCH    = 3'd3,
        CMD_INS_AFTER = 3'd4,
        CMD_DUMP      = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_WALK,
        ST_DEL_FIX,
        ST_AFT_ALLOC,
        ST_AFT_LINK
    } state_t;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_W-1:0]       slot;
        logic [POS_W-1:0]        position;
        logic [OUT_VALUE_W-1:0]  value;
        logic                    last;
    } res_t;

    function automatic res_t mk_res(status_t st, logic [SLOT_W-1:0] sl,
                                    logic [POS_W-1:0] ps,
                                    logic [OUT_VALUE_W-1:0] vl, logic lt);
        res_t r;
        r.status   = st;
        r.slot     = sl;
        r.position = ps;
        r.value    = vl;
        r.last     = lt;
        return r;
    endfunction

endpackage
`default_nettype wire

### src/pooled_linked_list_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pooled_linked_list_engine_unit: singly linked list in a fixed node pool
// six list commands over a value ram and a link ram, one node visited a cycle
// ----------------------------------------------------------------------------
// sequence: insert at head reads the free head on accept, then writes the node
// and registers its result in ST_ALLOC; commands that walk the list pass ST_WALK
// once per visited node; dump emits one result per cycle; busy is high until the
// last result; the walk is paced by the link ram read that chains node to node;
// results are never held off by the receiver
// reset: list empty, every node free, no clearing pass (link ram valid bits)

module pooled_linked_list_engine_unit #(
    parameter int POOL_NODES = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [pll_pkg::CMD_W-1:0]         cmd,
    input  wire logic signed [pll_pkg::IN_VALUE_W-1:0] new_value,
    input  wire logic signed [pll_pkg::IN_VALUE_W-1:0] key_value,
    output logic                                   strobe,
    output logic [pll_pkg::STATUS_W-1:0]           status,
    output logic [pll_pkg::SLOT_W-1:0]             slot,
    output logic [pll_pkg::POS_W-1:0]              position,
    output logic signed [pll_pkg::OUT_VALUE_W-1:0] element_value,
    output logic                                   last
);
    import pll_pkg::*;

    localparam int IW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam int PW = $clog2(POOL_NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

    // node rams
    logic signed [VALUE_BITS-1:0] vals_mem [POOL_NODES];
    logic [LW-1:0]                links_mem [POOL_NODES];
    logic [POOL_NODES-1:0]        link_vld_reg;

    logic                         v_we;
    logic [IW-1:0]                v_waddr;
    logic                         l_we;
    logic [IW-1:0]                l_waddr;
    logic [LW-1:0]                l_wdata;
    logic [IW-1:0]                rd_addr;
    logic signed [VALUE_BITS-1:0] val_rd_reg;
    logic [LW-1:0]                lnk_rd_reg;

    // sequencer
    state_t                       state_reg, state_next;
    cmd_t                         cmd_reg, cmd_next;
    logic signed [VALUE_BITS-1:0] nv_reg, nv_next;
    logic signed [VALUE_BITS-1:0] key_reg, key_next;
    logic [LW-1:0]                list_head_reg, list_head_next;
    logic [LW-1:0]                free_head_reg, free_head_next;
    logic [LW-1:0]                cur_reg, cur_next;
    logic [LW-1:0]                prev_reg, prev_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic [IW-1:0]                new_reg, new_next;
    logic [LW-1:0]                save_reg, save_next;

    logic                         strobe_reg, strobe_next;
    res_t                         res_reg, res_next;

    logic                         at_end;
    logic                         match;
    logic                         dump_last;

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vals_mem[v_waddr] <= nv_reg;
        end
        if (l_we)
        begin
            links_mem[l_waddr] <= l_wdata;
        end
        val_rd_reg <= vals_mem[rd_addr];
        // a link never written still holds its reset chain value
        lnk_rd_reg <= link_vld_reg[rd_addr] ? links_mem[rd_addr] : LW'(rd_addr) + LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
        end
        else if (l_we)
        begin
            link_vld_reg[l_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            list_head_reg <= NIL;
            free_head_reg <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        nv_reg   <= nv_next;
        key_reg  <= key_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        pos_reg  <= pos_next;
        new_reg  <= new_next;
        save_reg <= save_next;
        res_reg  <= res_next;
    end

    assign at_end    = (lnk_rd_reg >= NIL);
    assign match     = (val_rd_reg == key_reg);
    assign dump_last = at_end || (32'(pos_reg) == MAX_DUMP);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        nv_next        = nv_reg;
        key_next       = key_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        pos_next       = pos_reg;
        new_next       = new_reg;
        save_next      = save_reg;
        strobe_next    = 1'b0;
        res_next       = res_reg;
        rd_addr        = cur_reg[IW-1:0];
        v_we           = 1'b0;
        v_waddr        = new_reg;
        l_we           = 1'b0;
        l_waddr        = cur_reg[IW-1:0];
        l_wdata        = NIL;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd_t'(cmd);
                    nv_next  = VALUE_BITS'(new_value);
                    key_next = VALUE_BITS'(key_value);
                    case (cmd_t'(cmd))
                        CMD_INS_HEAD, CMD_INS_TAIL:
                        begin
                            if (free_head_reg >= NIL)
                            begin
                                strobe_next = 1'b1;
                                res_next    = mk_res(STS_FULL, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                rd_addr    = free_head_reg[IW-1:0];
                                state_next = ST_ALLOC;
                            end
                        end
                        CMD_DELETE, CMD_SEARCH, CMD_INS_AFTER, CMD_DUMP:
                        begin
                            if (list_head_reg >= NIL)
                            begin
                                strobe_next = 1'b1;
                                res_next    = mk_res(STS_EMPTY, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                rd_addr    = list_head_reg[IW-1:0];
                                cur_next   = list_head_reg;
                                prev_next  = NIL;
                                pos_next   = PW'(1);
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ALLOC:
            begin
                // lnk_rd_reg holds the second free node
                v_we           = 1'b1;
                v_waddr        = free_head_reg[IW-1:0];
                new_next       = free_head_reg[IW-1:0];
                free_head_next = lnk_rd_reg;
                l_we           = 1'b1;
                l_waddr        = free_head_reg[IW-1:0];
                if (cmd_reg == CMD_INS_HEAD || list_head_reg >= NIL)
                begin
                    l_wdata        = list_head_reg;
                    list_head_next = free_head_reg;
                    strobe_next    = 1'b1;
                    res_next       = mk_res(STS_OK, SLOT_W'(free_head_reg), '0, '0, 1'b1);
                    state_next     = ST_IDLE;
                end
                else
                begin
                    l_wdata    = NIL;
                    rd_addr    = list_head_reg[IW-1:0];
                    cur_next   = list_head_reg;
                    prev_next  = NIL;
                    pos_next   = PW'(1);
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                state_next = ST_IDLE;
                case (cmd_reg)
                    CMD_INS_TAIL:
                    begin
                        if (at_end)
                        begin
                            l_we        = 1'b1;
                            l_waddr     = cur_reg[IW-1:0];
                            l_wdata     = LW'(new_reg);
                            strobe_next = 1'b1;
                            res_next    = mk_res(STS_OK, SLOT_W'(new_reg), '0, '0, 1'b1);
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    CMD_DUMP:
                    begin
                        strobe_next = 1'b1;
                        res_next    = mk_res(STS_OK, SLOT_W'(cur_reg), POS_W'(pos_reg),
                                             OUT_VALUE_W'(val_rd_reg), dump_last);
                        if (!dump_last)
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    CMD_SEARCH, CMD_DELETE, CMD_INS_AFTER:
                    begin
                        if (match)
                        begin
                            if (cmd_reg == CMD_SEARCH)
                            begin
                                strobe_next = 1'b1;
                                res_next    = mk_res(STS_OK, SLOT_W'(cur_reg),
                                                     POS_W'(pos_reg), OUT_VALUE_W'(val_rd_reg),
                                                     1'b1);
                            end
                            else if (cmd_reg == CMD_DELETE)
                            begin
                                // freed node goes to the head of the free list
                                l_we           = 1'b1;
                                l_waddr        = cur_reg[IW-1:0];
                                l_wdata        = free_head_reg;
                                free_head_next = cur_reg;
                                if (prev_reg >= NIL)
                                begin
                                    list_head_next = lnk_rd_reg;
                                    strobe_next    = 1'b1;
                                    res_next       = mk_res(STS_OK, SLOT_W'(cur_reg),
                                                            POS_W'(pos_reg), '0, 1'b1);
                                end
                                else
                                begin
                                    save_next  = lnk_rd_reg;
                                    state_next = ST_DEL_FIX;
                                end
                            end
                            else if (free_head_reg >= NIL)
                            begin
                                strobe_next = 1'b1;
                                res_next    = mk_res(STS_FULL, '0, '0, '0, 1'b1);
                            end
                            else
                            begin
                                save_next  = lnk_rd_reg;
                                rd_addr    = free_head_reg[IW-1:0];
                                state_next = ST_AFT_ALLOC;
                            end
                        end
                        else if (at_end)
                        begin
                            strobe_next = 1'b1;
                            res_next    = mk_res(STS_NOT_FOUND, '0, '0, '0, 1'b1);
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
                // step to the next node, its read issued straight from the link
                if (state_next == ST_WALK)
                begin
                    rd_addr   = lnk_rd_reg[IW-1:0];
                    cur_next  = lnk_rd_reg;
                    prev_next = cur_reg;
                    pos_next  = pos_reg + PW'(1);
                end
            end

            ST_DEL_FIX:
            begin
                l_we        = 1'b1;
                l_waddr     = prev_reg[IW-1:0];
                l_wdata     = save_reg;
                strobe_next = 1'b1;
                res_next    = mk_res(STS_OK, SLOT_W'(cur_reg), POS_W'(pos_reg), '0, 1'b1);
                state_next  = ST_IDLE;
            end

            ST_AFT_ALLOC:
            begin
                v_we           = 1'b1;
                v_waddr        = free_head_reg[IW-1:0];
                new_next       = free_head_reg[IW-1:0];
                free_head_next = lnk_rd_reg;
                l_we           = 1'b1;
                l_waddr        = free_head_reg[IW-1:0];
                l_wdata        = save_reg;
                state_next     = ST_AFT_LINK;
            end

            ST_AFT_LINK:
            begin
                l_we        = 1'b1;
                l_waddr     = cur_reg[IW-1:0];
                l_wdata     = LW'(new_reg);
                strobe_next = 1'b1;
                res_next    = mk_res(STS_OK, SLOT_W'(new_reg), '0, '0, 1'b1);
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign strobe        = strobe_reg;
    assign status        = res_reg.status;
    assign slot          = res_reg.slot;
    assign position      = res_reg.position;
    assign element_value = res_reg.value;
    assign last          = res_reg.last;

    // a result only follows a request or ongoing work
    a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy || start))
        else $error("result without a request");

    // more results of the same request still to come
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("non-final result while idle");

    // unknown commands give nothing
    a_unknown_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd > CMD_DUMP)) |=> !strobe)
        else $error("result for unknown command");

    a_heads_range: assert property (@(posedge clk) disable iff (!rst_n)
        (list_head_reg <= NIL) && (free_head_reg <= NIL))
        else $error("list or free head out of range");

endmodule
`default_nettype wire
